[rtl/mtg_pkg.sv]
// Package for the Mersenne Twister generator: sizes, constants, sequencer states
// and the twist and tempering functions. It depends on nothing else.
`default_nettype none

package mtg_pkg;

    localparam int STATE_WORDS = 624;
    localparam int TWIST_SHIFT = 397;
    localparam int IDX_W       = $clog2(STATE_WORDS + 2);
    localparam int ADDR_W      = $clog2(STATE_WORDS);

    localparam logic [IDX_W-1:0]  IDX_TABLE_END = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0]  IDX_UNSEEDED  = IDX_W'(STATE_WORDS + 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST     = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] ADDR_SHIFT    = ADDR_W'(TWIST_SHIFT);
    localparam logic [ADDR_W-1:0] ADDR_WRAP     = ADDR_W'(STATE_WORDS - TWIST_SHIFT);

    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TWIST_XOR    = 32'h9908b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h80000000;
    localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_FIRST,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_TW_CUR,
        ST_TW_NXT,
        ST_TW_FAR,
        ST_TW_WRITE,
        ST_DRAW_READ,
        ST_DRAW_OUT
    } mtg_state_t;

    // New value of one table word from the current, following and far words.
    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] w;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        w = far ^ (y >> 1);
        if (y[0]) begin
            w = w ^ TWIST_XOR;
        end
        return w;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

[rtl/mersenne_twister_generator.sv]
// Top level of the MT19937 generator: state table memory, seed and twist
// sequencer, draw path and output register. Depends on mtg_pkg.
//
// Usage: every request on the s_ channel returns exactly one tempered 32-bit
// word on the m_ channel. s_tdata[0] is the restart flag: when set, the state
// table is rebuilt from the seed register before the word is drawn. The seed
// register is written over the cfg_ channel (always ready); the user must write
// it only while the block is idle (not enforced by the block); it resets to 5489.
// Draw path: a draw from a ready table reads the table word, then loads the
// tempered word into the output register for m_tdata. A new request is taken
// only once the sequencer is back in idle after that load. Every 624th draw
// first twists the whole table, with three reads and one write per word on
// the one port (current, following and far word reads, then the write).
// Seeding writes the seed to word 0, then each further word in a multiply
// state and an add state because of the registered multiplier; it runs before
// the first draw after reset and on every restart, followed by a twist.
// Reset: the read index is set to "not yet seeded"; the table is not
// cleared, as the first draw always seeds it first. No clearing pass runs.
// Stall: the result sits in an output register; the next request is taken
// while it waits, but that request's word is held back until the register
// has been emptied.
`default_nettype none

module mersenne_twister_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel. s_tdata fields from bit 0: restart (1 bit), zero fill.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // Result channel. m_tdata fields from bit 0: random_word (32 bits).
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    // Seed register write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import mtg_pkg::*;

    // State table: one port, registered read data.
    logic [31:0] table_mem [STATE_WORDS];
    logic [31:0] rdata_reg;

    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [31:0]       mem_wr_data;

    mtg_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] k_reg, k_next;        // word counter for seed and twist
    logic [IDX_W-1:0]  idx_reg, idx_next;    // read index, STATE_WORDS+1 = unseeded
    logic [31:0]       x_reg, x_next;        // previous seed word
    logic [31:0]       prod_reg, prod_next;  // registered seed product
    logic [31:0]       cur_reg, cur_next;
    logic [31:0]       nxt_reg, nxt_next;
    logic [31:0]       seed_reg, seed_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;

    logic              req_fire;
    logic              out_load;
    logic [ADDR_W-1:0] k_nxt_addr;
    logic [ADDR_W-1:0] k_far_addr;
    logic [31:0]       seed_mix;
    logic [31:0]       seed_word;

    assign req_fire   = s_tvalid && s_tready;
    assign k_nxt_addr = (k_reg == ADDR_LAST) ? '0 : k_reg + ADDR_W'(1);
    assign k_far_addr = (k_reg < ADDR_WRAP) ? k_reg + ADDR_SHIFT : k_reg - ADDR_WRAP;
    assign seed_mix   = x_reg ^ (x_reg >> 30);
    assign seed_word  = prod_reg + 32'(k_reg);

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_fire) begin
                    if (s_tdata[0] || idx_reg == IDX_UNSEEDED) begin
                        state_next = ST_SEED_FIRST;
                    end else if (idx_reg == IDX_TABLE_END) begin
                        state_next = ST_TW_CUR;
                    end else begin
                        state_next = ST_DRAW_READ;
                    end
                end
            end
            ST_SEED_FIRST: state_next = ST_SEED_MUL;
            ST_SEED_MUL:   state_next = ST_SEED_ADD;
            ST_SEED_ADD: begin
                state_next = (k_reg == ADDR_LAST) ? ST_TW_CUR : ST_SEED_MUL;
            end
            ST_TW_CUR: state_next = ST_TW_NXT;
            ST_TW_NXT: state_next = ST_TW_FAR;
            ST_TW_FAR: state_next = ST_TW_WRITE;
            ST_TW_WRITE: begin
                state_next = (k_reg == ADDR_LAST) ? ST_DRAW_READ : ST_TW_CUR;
            end
            ST_DRAW_READ: state_next = ST_DRAW_OUT;
            ST_DRAW_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory controls, request ready and output load.
    always_comb begin
        s_tready    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = k_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = k_reg;
        mem_wr_data = seed_word;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SEED_FIRST: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = seed_reg;
            end
            ST_SEED_ADD: mem_wr_en = 1'b1;
            ST_TW_CUR: mem_rd_en = 1'b1;
            ST_TW_NXT: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = k_nxt_addr;
            end
            ST_TW_FAR: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = k_far_addr;
            end
            ST_TW_WRITE: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = twist_word(cur_reg, nxt_reg, rdata_reg);
            end
            ST_DRAW_READ: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg[ADDR_W-1:0];
            end
            ST_DRAW_OUT: out_load = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // Datapath register updates.
    always_comb begin
        k_next         = k_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        seed_next      = (cfg_valid && cfg_ready) ? cfg_data : seed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = temper(rdata_reg);
            idx_next       = idx_reg + IDX_W'(1);
        end

        case (state_reg)
            ST_SEED_FIRST: begin
                x_next = seed_reg;
                k_next = ADDR_W'(1);
            end
            ST_SEED_MUL: prod_next = SEED_MULT * seed_mix;
            ST_SEED_ADD: begin
                x_next = seed_word;
                if (k_reg == ADDR_LAST) begin
                    k_next   = '0;
                    idx_next = IDX_TABLE_END;
                end else begin
                    k_next = k_reg + ADDR_W'(1);
                end
            end
            ST_TW_CUR: begin
                if (idx_reg == IDX_TABLE_END) begin
                    k_next = k_reg;
                end
            end
            ST_TW_NXT: cur_next = rdata_reg;
            ST_TW_FAR: nxt_next = rdata_reg;
            ST_TW_WRITE: begin
                if (k_reg == ADDR_LAST) begin
                    k_next   = '0;
                    idx_next = '0;
                end else begin
                    k_next = k_reg + ADDR_W'(1);
                end
            end
            default: ;
        endcase

        // A twist that starts straight from idle begins at word 0.
        if (state_reg == ST_IDLE && state_next == ST_TW_CUR) begin
            k_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            table_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rdata_reg <= table_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            idx_reg       <= IDX_UNSEEDED;
            seed_reg      <= DEFAULT_SEED;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
